// ===== src/ecnf_pkg.sv =====
// Shared types, constants and helpers for the event camera noise filter.
`timescale 1ns / 1ps
package ecnf_pkg;

  localparam int DEF_WIDTH      = 256;
  localparam int DEF_HEIGHT     = 256;
  localparam int DEF_COUNT_BITS = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam logic [4:0]  RST_MODE   = 5'h06;
  localparam logic [3:0]  RST_SMIN   = 4'd1;
  localparam logic [3:0]  RST_SMAX   = 4'd8;
  localparam logic [23:0] RST_WINDOW = 24'd2000;
  localparam logic [23:0] RST_REFR   = 24'd100;
  localparam logic [24:0] RST_LTIME  = 25'd1000000;
  localparam logic [23:0] RST_THR    = 24'd10000;

  localparam int MODE_HOT  = 0;
  localparam int MODE_REFR = 1;
  localparam int MODE_NB   = 2;
  localparam int MODE_TWO  = 3;
  localparam int MODE_POL  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_SMIN   = 3'd1,
    CFG_SMAX   = 3'd2,
    CFG_WINDOW = 3'd3,
    CFG_REFR   = 3'd4,
    CFG_LTIME  = 3'd5,
    CFG_THR    = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VERDICT_PASS    = 2'd0,
    VERDICT_HOT     = 2'd1,
    VERDICT_REFR    = 2'd2,
    VERDICT_NO_SUPP = 2'd3
  } verdict_e;

  typedef enum logic [0:0] {
    OP_EVENT = 1'b0,
    OP_LEARN = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [4:0]  mode;
    logic [3:0]  smin;
    logic [3:0]  smax;
    logic [23:0] window;
    logic [23:0] refr;
    logic [24:0] ltime;
    logic [23:0] thr;
  } cfg_t;

  typedef struct packed {
    logic stamp_we;
    logic count_we;
    logic mask_we;
    logic mask_wd;
  } store_ctl_t;

  function automatic logic signed [1:0] nb_dx(input logic [2:0] k);
    logic signed [1:0] d;
    case (k)
      3'd0, 3'd3, 3'd5: d = -2'sd1;
      3'd1, 3'd6:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] nb_dy(input logic [2:0] k);
    logic signed [1:0] d;
    case (k)
      3'd0, 3'd1, 3'd2: d = -2'sd1;
      3'd3, 3'd4:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

endpackage

// ===== src/event_camera_noise_filter.sv =====
// Top level of the event camera noise filter: configuration registers and wiring.
//
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    opcode_i pos_x_i pos_y_i stamp_i polarity_i
// out       output     out_valid_o / out_ready_i  out_x_o out_y_o out_stamp_o out_polarity_o
//                                                 verdict_o learning_done_o
// cfg       input      cfg_we_i                   cfg_idx_i cfg_data_i
//
// A hot event is emitted without a stamp write; a refractory event, or one with the neighbour
// check off, goes straight to the stamp write. The single-level neighbour scan does one stamp
// memory read per neighbour, and two-level mode rescans around each supporting neighbour in turn
// until one supports. An event that ends learning adds a hot mask rebuild sweep over all pixels.
// After reset a clearing pass over every pixel runs before the first transaction.
// Input is taken only between events; a stalled result holds the next one in its last step.
`timescale 1ns / 1ps
module event_camera_noise_filter import ecnf_pkg::*; #(
  parameter int WIDTH      = DEF_WIDTH,
  parameter int HEIGHT     = DEF_HEIGHT,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [7:0]            pos_x_i,
  input  logic [7:0]            pos_y_i,
  input  logic [31:0]           stamp_i,
  input  logic                  polarity_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_x_o,
  output logic [7:0]            out_y_o,
  output logic [31:0]           out_stamp_o,
  output logic                  out_polarity_o,
  output logic [1:0]            verdict_o,
  output logic                  learning_done_o
);
  localparam int NPIX   = WIDTH * HEIGHT;
  localparam int ADDR_W = $clog2(NPIX);

  cfg_t cfg_q, cfg_d;

  store_ctl_t            st_ctl;
  logic [ADDR_W-1:0]     st_waddr, st_stamp_raddr, st_cm_raddr;
  logic [32:0]           st_stamp_wd, st_stamp_rd;
  logic [COUNT_BITS-1:0] st_count_wd, st_count_rd;
  logic                  st_mask_rd;
  logic [31:0]           gap_stored;
  logic [23:0]           gap_limit;
  logic                  gap_below;
  logic [31:0]           gap_stamp_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:   cfg_d.mode   = cfg_data_i[4:0];
        CFG_SMIN:   cfg_d.smin   = cfg_data_i[3:0];
        CFG_SMAX:   cfg_d.smax   = cfg_data_i[3:0];
        CFG_WINDOW: cfg_d.window = cfg_data_i[23:0];
        CFG_REFR:   cfg_d.refr   = cfg_data_i[23:0];
        CFG_LTIME:  cfg_d.ltime  = cfg_data_i[24:0];
        CFG_THR:    cfg_d.thr    = cfg_data_i[23:0];
        default:    cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: RST_MODE, smin: RST_SMIN, smax: RST_SMAX, window: RST_WINDOW,
                 refr: RST_REFR, ltime: RST_LTIME, thr: RST_THR};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      gap_stamp_q <= stamp_i;
    end
  end

  ecnf_ctrl #(
    .WIDTH      (WIDTH),
    .HEIGHT     (HEIGHT),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .stamp_i          (stamp_i),
    .polarity_i       (polarity_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_x_o          (out_x_o),
    .out_y_o          (out_y_o),
    .out_stamp_o      (out_stamp_o),
    .out_polarity_o   (out_polarity_o),
    .verdict_o        (verdict_o),
    .learning_done_o  (learning_done_o),
    .st_ctl_o         (st_ctl),
    .st_waddr_o       (st_waddr),
    .st_stamp_wd_o    (st_stamp_wd),
    .st_count_wd_o    (st_count_wd),
    .st_stamp_raddr_o (st_stamp_raddr),
    .st_cm_raddr_o    (st_cm_raddr),
    .st_stamp_rd_i    (st_stamp_rd),
    .st_count_rd_i    (st_count_rd),
    .st_mask_rd_i     (st_mask_rd),
    .gap_stored_o     (gap_stored),
    .gap_limit_o      (gap_limit),
    .gap_below_i      (gap_below)
  );

  ecnf_pixel_store #(
    .NPIX       (NPIX),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk_i         (clk_i),
    .ctl_i         (st_ctl),
    .waddr_i       (st_waddr),
    .stamp_wd_i    (st_stamp_wd),
    .count_wd_i    (st_count_wd),
    .stamp_raddr_i (st_stamp_raddr),
    .cm_raddr_i    (st_cm_raddr),
    .stamp_rd_o    (st_stamp_rd),
    .count_rd_o    (st_count_rd),
    .mask_rd_o     (st_mask_rd)
  );

  ecnf_gap_unit u_gap (
    .stamp_i  (gap_stamp_q),
    .stored_i (gap_stored),
    .limit_i  (gap_limit),
    .below_o  (gap_below)
  );
endmodule

// ===== src/ecnf_gap_unit.sv =====
// Shared signed time-gap comparator.
`timescale 1ns / 1ps
module ecnf_gap_unit import ecnf_pkg::*; (
  input  logic [31:0] stamp_i,
  input  logic [31:0] stored_i,
  input  logic [23:0] limit_i,
  output logic        below_o
);
  logic signed [33:0] gap;

  assign gap     = $signed({2'b00, stamp_i}) - $signed({2'b00, stored_i});
  assign below_o = gap < $signed({10'd0, limit_i});
endmodule

// ===== src/ecnf_pixel_store.sv =====
// Per-pixel stamp, learn count and hot mask memories.
`timescale 1ns / 1ps
module ecnf_pixel_store import ecnf_pkg::*; #(
  parameter int NPIX       = DEF_WIDTH * DEF_HEIGHT,
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  localparam int ADDR_W    = $clog2(NPIX)
) (
  input  logic                  clk_i,
  input  store_ctl_t            ctl_i,
  input  logic [ADDR_W-1:0]     waddr_i,
  input  logic [32:0]           stamp_wd_i,
  input  logic [COUNT_BITS-1:0] count_wd_i,
  input  logic [ADDR_W-1:0]     stamp_raddr_i,
  input  logic [ADDR_W-1:0]     cm_raddr_i,
  output logic [32:0]           stamp_rd_o,
  output logic [COUNT_BITS-1:0] count_rd_o,
  output logic                  mask_rd_o
);
  logic [32:0]           stamp_mem [NPIX];
  logic [COUNT_BITS-1:0] count_mem [NPIX];
  logic                  mask_mem  [NPIX];

  always_ff @(posedge clk_i) begin
    if (ctl_i.stamp_we) begin
      stamp_mem[waddr_i] <= stamp_wd_i;
    end
    stamp_rd_o <= stamp_mem[stamp_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.count_we) begin
      count_mem[waddr_i] <= count_wd_i;
    end
    count_rd_o <= count_mem[cm_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mask_we) begin
      mask_mem[waddr_i] <= ctl_i.mask_wd;
    end
    mask_rd_o <= mask_mem[cm_raddr_i];
  end
endmodule

// ===== src/ecnf_ctrl.sv =====
// Sequencer: own-pixel checks, learning sweep, neighbour scans and result register.
`timescale 1ns / 1ps
module ecnf_ctrl import ecnf_pkg::*; #(
  parameter int WIDTH      = DEF_WIDTH,
  parameter int HEIGHT     = DEF_HEIGHT,
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  localparam int NPIX      = WIDTH * HEIGHT,
  localparam int ADDR_W    = $clog2(NPIX)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [7:0]            pos_x_i,
  input  logic [7:0]            pos_y_i,
  input  logic [31:0]           stamp_i,
  input  logic                  polarity_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_x_o,
  output logic [7:0]            out_y_o,
  output logic [31:0]           out_stamp_o,
  output logic                  out_polarity_o,
  output logic [1:0]            verdict_o,
  output logic                  learning_done_o,
  output store_ctl_t            st_ctl_o,
  output logic [ADDR_W-1:0]     st_waddr_o,
  output logic [32:0]           st_stamp_wd_o,
  output logic [COUNT_BITS-1:0] st_count_wd_o,
  output logic [ADDR_W-1:0]     st_stamp_raddr_o,
  output logic [ADDR_W-1:0]     st_cm_raddr_o,
  input  logic [32:0]           st_stamp_rd_i,
  input  logic [COUNT_BITS-1:0] st_count_rd_i,
  input  logic                  st_mask_rd_i,
  output logic [31:0]           gap_stored_o,
  output logic [23:0]           gap_limit_o,
  input  logic                  gap_below_i
);
  localparam int MAXD = (WIDTH > HEIGHT) ? WIDTH : HEIGHT;
  localparam int CW   = (($clog2(MAXD) > 8) ? $clog2(MAXD) : 8) + 2;
  localparam int CMPW = (COUNT_BITS > 24) ? COUNT_BITS : 24;
  localparam int SW   = ADDR_W + 1;

  typedef enum logic [9:0] {
    ST_CLEAR   = 10'b0000000001,
    ST_IDLE    = 10'b0000000010,
    ST_OWN_RD  = 10'b0000000100,
    ST_OWN_CHK = 10'b0000001000,
    ST_SWEEP   = 10'b0000010000,
    ST_DECIDE  = 10'b0000100000,
    ST_SCAN    = 10'b0001000000,
    ST_EVAL    = 10'b0010000000,
    ST_WRITE   = 10'b0100000000,
    ST_EMIT    = 10'b1000000000
  } state_e;

  typedef logic signed [CW-1:0] coord_t;

  function automatic logic [ADDR_W-1:0] pix_addr(input coord_t cx, input coord_t cy);
    return ADDR_W'(cy) * ADDR_W'(WIDTH) + ADDR_W'(cx);
  endfunction

  function automatic logic in_sensor(input coord_t cx, input coord_t cy);
    return (cx >= 0) && (cy >= 0) && (cx < $signed(CW'(WIDTH))) &&
           (cy < $signed(CW'(HEIGHT)));
  endfunction

  state_e state_q, state_d;

  logic active_q, active_d, pending_q, pending_d, end_q, end_d;
  logic [31:0] start_q, start_d;
  logic [SW-1:0] s_q, s_d;
  logic sw_vld_q, sw_vld_d;
  logic [ADDR_W-1:0] sw_addr_q, sw_addr_d;

  logic [7:0] x_q, x_d, y_q, y_d;
  logic [31:0] t_q, t_d, own_stamp_q, own_stamp_d;
  logic pol_q, pol_d, hot_q, hot_d, done_q, done_d;
  logic [1:0] verdict_q, verdict_d;
  logic [ADDR_W-1:0] idx_q, idx_d;

  logic [3:0] k_q, k_d, n_q, n_d, j_q, j_d;
  logic p_vld_q, p_vld_d, lvl2_q, lvl2_d, found_q, found_d;
  coord_t cx_q, cx_d, cy_q, cy_d, px_q, px_d, py_q, py_d;
  coord_t list_x_q [8];
  coord_t list_y_q [8];
  logic list_we;

  logic out_valid_q, out_valid_d;
  logic [7:0] ox_q, oy_q;
  logic [31:0] ot_q;
  logic op_q, odone_q, out_load;
  logic [1:0] ov_q;

  coord_t nx, ny, ex, ey;
  logic supp, n_ok, learn_go;
  logic [32:0] end_at;

  assign ex       = coord_t'({1'b0, pos_x_i});
  assign ey       = coord_t'({1'b0, pos_y_i});
  assign nx       = cx_q + coord_t'(nb_dx(k_q[2:0]));
  assign ny       = cy_q + coord_t'(nb_dy(k_q[2:0]));
  assign supp     = gap_below_i &&
                    !(cfg_i.mode[MODE_POL] && (st_stamp_rd_i[0] != pol_q));
  assign n_ok     = (n_q >= cfg_i.smin) && (n_q <= cfg_i.smax);
  assign learn_go = pending_q && !active_q;
  assign end_at   = {1'b0, (learn_go ? stamp_i : start_q)} + {8'd0, cfg_i.ltime};

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    pending_d   = pending_q;
    end_d       = end_q;
    start_d     = start_q;
    s_d         = s_q;
    sw_vld_d    = 1'b0;
    sw_addr_d   = sw_addr_q;
    x_d         = x_q;
    y_d         = y_q;
    t_d         = t_q;
    pol_d       = pol_q;
    idx_d       = idx_q;
    own_stamp_d = own_stamp_q;
    hot_d       = hot_q;
    done_d      = done_q;
    verdict_d   = verdict_q;
    k_d         = k_q;
    n_d         = n_q;
    j_d         = j_q;
    p_vld_d     = 1'b0;
    lvl2_d      = lvl2_q;
    found_d     = found_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    px_d        = px_q;
    py_d        = py_q;
    list_we     = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    st_ctl_o         = '0;
    st_waddr_o       = idx_q;
    st_stamp_wd_o    = {t_q, pol_q};
    st_count_wd_o    = '0;
    st_stamp_raddr_o = idx_q;
    st_cm_raddr_o    = idx_q;
    gap_stored_o     = st_stamp_rd_i[32:1];
    gap_limit_o      = cfg_i.window;

    unique case (state_q)
      ST_CLEAR: begin
        st_ctl_o.stamp_we = 1'b1;
        st_ctl_o.count_we = 1'b1;
        st_ctl_o.mask_we  = 1'b1;
        st_stamp_wd_o     = '0;
        st_waddr_o        = s_q[ADDR_W-1:0];
        s_d               = s_q + 1'b1;
        if (s_q == SW'(NPIX - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          x_d    = pos_x_i;
          y_d    = pos_y_i;
          t_d    = stamp_i;
          pol_d  = polarity_i;
          idx_d  = pix_addr(ex, ey);
          done_d = 1'b0;
          if (opcode_i == OP_LEARN) begin
            if (!active_q) begin
              pending_d = 1'b1;
            end
          end else if (!in_sensor(ex, ey)) begin
            verdict_d = VERDICT_NO_SUPP;
            state_d   = ST_EMIT;
          end else begin
            if (learn_go) begin
              start_d  = stamp_i;
              active_d = 1'b1;
            end
            pending_d = 1'b0;
            end_d     = (active_q || learn_go) && ({1'b0, stamp_i} > end_at);
            verdict_d = VERDICT_PASS;
            state_d   = ST_OWN_RD;
          end
        end
      end
      ST_OWN_RD: begin
        state_d = ST_OWN_CHK;
      end
      ST_OWN_CHK: begin
        own_stamp_d = st_stamp_rd_i[32:1];
        hot_d       = st_mask_rd_i;
        if (active_q) begin
          st_ctl_o.count_we = 1'b1;
          st_count_wd_o     = (&st_count_rd_i) ? st_count_rd_i : st_count_rd_i + 1'b1;
        end
        if (end_q) begin
          active_d = 1'b0;
          done_d   = 1'b1;
          s_d      = '0;
          state_d  = ST_SWEEP;
        end else begin
          state_d = ST_DECIDE;
        end
      end
      ST_SWEEP: begin
        st_cm_raddr_o = s_q[ADDR_W-1:0];
        if (s_q != SW'(NPIX)) begin
          sw_vld_d  = 1'b1;
          sw_addr_d = s_q[ADDR_W-1:0];
          s_d       = s_q + 1'b1;
        end
        if (sw_vld_q) begin
          st_waddr_o        = sw_addr_q;
          st_ctl_o.count_we = 1'b1;
          st_ctl_o.mask_we  = 1'b1;
          st_ctl_o.mask_wd  = CMPW'(st_count_rd_i) >= CMPW'(cfg_i.thr);
          if (sw_addr_q == idx_q) begin
            hot_d = st_ctl_o.mask_wd;
          end
        end else if (s_q == SW'(NPIX)) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        gap_stored_o = own_stamp_q;
        gap_limit_o  = cfg_i.refr;
        cx_d         = coord_t'({1'b0, x_q});
        cy_d         = coord_t'({1'b0, y_q});
        k_d          = '0;
        n_d          = '0;
        lvl2_d       = 1'b0;
        if (cfg_i.mode[MODE_HOT] && hot_q) begin
          verdict_d = VERDICT_HOT;
          state_d   = ST_EMIT;
        end else if (cfg_i.mode[MODE_REFR] && gap_below_i) begin
          verdict_d = VERDICT_REFR;
          state_d   = ST_WRITE;
        end else if (cfg_i.mode[MODE_NB]) begin
          state_d = ST_SCAN;
        end else begin
          verdict_d = VERDICT_PASS;
          state_d   = ST_WRITE;
        end
      end
      ST_SCAN: begin
        st_stamp_raddr_o = pix_addr(nx, ny);
        if (k_q != 4'd8) begin
          p_vld_d = in_sensor(nx, ny);
          px_d    = nx;
          py_d    = ny;
          k_d     = k_q + 1'b1;
        end else begin
          state_d = ST_EVAL;
        end
        if (p_vld_q && supp) begin
          if (lvl2_q) begin
            found_d = 1'b1;
          end else begin
            list_we = 1'b1;
            n_d     = n_q + 1'b1;
          end
        end
      end
      ST_EVAL: begin
        if (!lvl2_q) begin
          if (!n_ok) begin
            verdict_d = VERDICT_NO_SUPP;
            state_d   = ST_WRITE;
          end else if (!cfg_i.mode[MODE_TWO]) begin
            verdict_d = VERDICT_PASS;
            state_d   = ST_WRITE;
          end else begin
            lvl2_d  = 1'b1;
            found_d = 1'b0;
            j_d     = '0;
          end
        end else if (found_q) begin
          verdict_d = VERDICT_PASS;
          state_d   = ST_WRITE;
        end else if (j_q == n_q) begin
          verdict_d = VERDICT_NO_SUPP;
          state_d   = ST_WRITE;
        end else begin
          cx_d    = list_x_q[j_q[2:0]];
          cy_d    = list_y_q[j_q[2:0]];
          j_d     = j_q + 1'b1;
          k_d     = '0;
          state_d = ST_SCAN;
        end
      end
      ST_WRITE: begin
        st_ctl_o.stamp_we = 1'b1;
        state_d           = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      active_q    <= 1'b0;
      pending_q   <= 1'b0;
      end_q       <= 1'b0;
      start_q     <= '0;
      s_q         <= '0;
      sw_vld_q    <= 1'b0;
      p_vld_q     <= 1'b0;
      lvl2_q      <= 1'b0;
      found_q     <= 1'b0;
      k_q         <= '0;
      n_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      pending_q   <= pending_d;
      end_q       <= end_d;
      start_q     <= start_d;
      s_q         <= s_d;
      sw_vld_q    <= sw_vld_d;
      p_vld_q     <= p_vld_d;
      lvl2_q      <= lvl2_d;
      found_q     <= found_d;
      k_q         <= k_d;
      n_q         <= n_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sw_addr_q   <= sw_addr_d;
    x_q         <= x_d;
    y_q         <= y_d;
    t_q         <= t_d;
    pol_q       <= pol_d;
    idx_q       <= idx_d;
    own_stamp_q <= own_stamp_d;
    hot_q       <= hot_d;
    done_q      <= done_d;
    verdict_q   <= verdict_d;
    cx_q        <= cx_d;
    cy_q        <= cy_d;
    px_q        <= px_d;
    py_q        <= py_d;
    if (list_we) begin
      list_x_q[n_q[2:0]] <= px_q;
      list_y_q[n_q[2:0]] <= py_q;
    end
    if (out_load) begin
      ox_q    <= x_q;
      oy_q    <= y_q;
      ot_q    <= t_q;
      op_q    <= pol_q;
      ov_q    <= verdict_q;
      odone_q <= done_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_x_o         = ox_q;
  assign out_y_o         = oy_q;
  assign out_stamp_o     = ot_q;
  assign out_polarity_o  = op_q;
  assign verdict_o       = ov_q;
  assign learning_done_o = odone_q;

  a_no_pending_while_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> !pending_q) else $error("learn start pending while learning");

  a_sweep_idle_learning: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> !active_q) else $error("sweep while learning active");

  a_support_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_q <= 4'd8) && (k_q <= 4'd8)) else $error("neighbour counter overrun");

  a_sweep_covers_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) && (state_d == ST_DECIDE) |-> (s_q == SW'(NPIX)))
    else $error("sweep left early");
endmodule
